// ===== rtl/core/doubly_linked_key_list_macros.svh =====
// assertion macros shared by the checker of the linked key list
`ifndef DOUBLY_LINKED_KEY_LIST_MACROS_SVH
`define DOUBLY_LINKED_KEY_LIST_MACROS_SVH

// property checked at every clock edge outside reset
`define DLKL_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("linked key list: property violated");

// property that must also hold while reset is applied
`define DLKL_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("linked key list: reset property violated");

`endif

// ===== rtl/core/dlkl_pkg.sv =====
// types, codes and control structs of the linked key list
`timescale 1ns / 1ps

package dlkl_pkg;

    localparam int KEY_W    = 32;
    localparam int SLOT_W   = 4;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    // a traversal emits at most this many keys
    localparam int RES_MAX  = 16;

    typedef logic [CMD_W-1:0]       t_cmd;
    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [STATUS_W-1:0]    t_status;
    typedef logic [SLOT_W-1:0]      t_slot;
    typedef logic [1:0]             t_slot_sel;

    // commands
    localparam t_cmd CMD_INS_FRONT = 3'd0;
    localparam t_cmd CMD_INS_BACK  = 3'd1;
    localparam t_cmd CMD_INS_AFTER = 3'd2;
    localparam t_cmd CMD_DELETE    = 3'd3;
    localparam t_cmd CMD_SEARCH    = 3'd4;
    localparam t_cmd CMD_CLEAR     = 3'd5;
    localparam t_cmd CMD_TRAVERSE  = 3'd6;
    localparam t_cmd CMD_UNUSED    = 3'd7;

    // result status codes
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_FULL      = 2'd2;
    localparam t_status ST_EMPTY     = 2'd3;

    // source of the slot field of a result
    localparam t_slot_sel SLOT_NONE  = 2'd0;
    localparam t_slot_sel SLOT_ALLOC = 2'd1;
    localparam t_slot_sel SLOT_CUR   = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic      load;
        logic      step;
        logic      wr_new;
        logic      wr_link;
        logic      clear;
        logic      emit;
        t_status   status;
        logic      key_sel;
        t_slot_sel slot_sel;
        logic      last;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic cur_null;
        logic match;
        logic next_null;
        logic cnt_last;
        logic full;
        logic empty;
        logic out_room;
    } t_dp_stat;

endpackage

// ===== rtl/core/dlkl_req_if.sv =====
// command channel of the linked key list
`timescale 1ns / 1ps

interface dlkl_req_if;
    logic            valid;
    logic            ready;
    dlkl_pkg::t_cmd  cmd;
    dlkl_pkg::t_key  key;
    dlkl_pkg::t_key  anchor_key;

    modport source (output valid, output cmd, output key, output anchor_key, input ready);
    modport sink (input valid, input cmd, input key, input anchor_key, output ready);
endinterface

// ===== rtl/core/dlkl_rsp_if.sv =====
// result channel of the linked key list
`timescale 1ns / 1ps

interface dlkl_rsp_if;
    logic              valid;
    logic              ready;
    dlkl_pkg::t_status status;
    dlkl_pkg::t_key    key_out;
    dlkl_pkg::t_slot   slot;
    logic              last;

    modport source (output valid, output status, output key_out, output slot, output last,
                    input ready);
    modport sink (input valid, input status, input key_out, input slot, input last,
                  output ready);
endinterface

// ===== rtl/core/dlkl_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module dlkl_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/dlkl_datapath.sv =====
// node pool, links, free map, walk pointer and result register
`timescale 1ns / 1ps

module dlkl_datapath #(
    parameter int POOL_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dlkl_pkg::t_cmd      i_cmd,
    input  dlkl_pkg::t_key      i_key,
    input  dlkl_pkg::t_key      i_anchor_key,
    input  dlkl_pkg::t_dp_cmd   i_ctl,
    output dlkl_pkg::t_dp_stat  o_stat,
    output logic                o_valid,
    input  logic                i_ready,
    output dlkl_pkg::t_status   o_status,
    output dlkl_pkg::t_key      o_key_out,
    output dlkl_pkg::t_slot     o_slot,
    output logic                o_last
);

    localparam int IW        = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int LW        = $clog2(POOL_DEPTH + 1);
    localparam int RES_LIMIT = (POOL_DEPTH < dlkl_pkg::RES_MAX) ? POOL_DEPTH
                                                                 : dlkl_pkg::RES_MAX;
    localparam int CW        = (RES_LIMIT > 1) ? $clog2(RES_LIMIT) : 1;
    localparam logic [LW-1:0] NULL_LINK = LW'(POOL_DEPTH);
    localparam logic [CW-1:0] CNT_END   = CW'(RES_LIMIT - 1);

    // control state
    logic [LW-1:0]         r_head, n_head;
    logic [LW-1:0]         r_tail, n_tail;
    logic [POOL_DEPTH-1:0] r_free, n_free;
    logic                  r_out_valid;

    // working registers
    logic [LW-1:0]      r_cur, n_cur;
    logic [LW-1:0]      r_slot;
    logic [CW-1:0]      r_cnt;
    dlkl_pkg::t_cmd     r_cmd;
    dlkl_pkg::t_key     r_key;
    dlkl_pkg::t_key     r_skey;
    dlkl_pkg::t_status  r_status;
    dlkl_pkg::t_key     r_key_out;
    dlkl_pkg::t_slot    r_slot_out;
    logic               r_last;

    // ram ports
    logic [dlkl_pkg::KEY_W-1:0] key_rd;
    logic [LW-1:0]              next_rd, prev_rd;
    logic                       next_we, prev_we;
    logic [LW-1:0]              next_waddr, prev_waddr;
    logic [LW-1:0]              next_wdata, prev_wdata;

    // allocation and slot formatting
    logic [POOL_DEPTH-1:0]          fm_low;
    logic [LW-1:0]                  free_idx;
    logic [LW+dlkl_pkg::SLOT_W-1:0] cur_ext, slot_ext;
    dlkl_pkg::t_slot                slot_sel_val;

    // node storage: the read address always follows the next walk position
    dlkl_ram #(.WIDTH(dlkl_pkg::KEY_W), .DEPTH(POOL_DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr_new),
        .i_waddr (r_slot[IW-1:0]),
        .i_wdata (r_key),
        .i_raddr (n_cur[IW-1:0]),
        .o_rdata (key_rd)
    );

    dlkl_ram #(.WIDTH(LW), .DEPTH(POOL_DEPTH)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr[IW-1:0]),
        .i_wdata (next_wdata),
        .i_raddr (n_cur[IW-1:0]),
        .o_rdata (next_rd)
    );

    dlkl_ram #(.WIDTH(LW), .DEPTH(POOL_DEPTH)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr[IW-1:0]),
        .i_wdata (prev_wdata),
        .i_raddr (n_cur[IW-1:0]),
        .o_rdata (prev_rd)
    );

    // walk pointer
    always_comb begin
        if (i_ctl.load) begin
            n_cur = r_head;
        end else if (i_ctl.step) begin
            n_cur = next_rd;
        end else begin
            n_cur = r_cur;
        end
    end

    // lowest free slot: isolate the lowest set bit, then encode it
    assign fm_low = r_free & (~r_free + POOL_DEPTH'(1));

    always_comb begin
        free_idx = '0;
        for (int i = 0; i < POOL_DEPTH; i++) begin
            if (fm_low[i]) begin
                free_idx = free_idx | LW'(i);
            end
        end
    end

    // link writes for a new node and for relinking its neighbours
    always_comb begin
        next_we    = 1'b0;
        prev_we    = 1'b0;
        next_waddr = r_slot;
        prev_waddr = r_slot;
        next_wdata = NULL_LINK;
        prev_wdata = NULL_LINK;
        if (i_ctl.wr_new) begin
            next_we = 1'b1;
            prev_we = 1'b1;
            case (r_cmd)
                dlkl_pkg::CMD_INS_FRONT: begin
                    next_wdata = r_head;
                    prev_wdata = NULL_LINK;
                end
                dlkl_pkg::CMD_INS_BACK: begin
                    next_wdata = NULL_LINK;
                    prev_wdata = r_tail;
                end
                default: begin
                    next_wdata = next_rd;
                    prev_wdata = r_cur;
                end
            endcase
        end else if (i_ctl.wr_link) begin
            case (r_cmd)
                dlkl_pkg::CMD_INS_FRONT: begin
                    prev_we    = (r_head != NULL_LINK);
                    prev_waddr = r_head;
                    prev_wdata = r_slot;
                end
                dlkl_pkg::CMD_INS_BACK: begin
                    next_we    = (r_tail != NULL_LINK);
                    next_waddr = r_tail;
                    next_wdata = r_slot;
                end
                dlkl_pkg::CMD_INS_AFTER: begin
                    next_we    = 1'b1;
                    next_waddr = r_cur;
                    next_wdata = r_slot;
                    prev_we    = (next_rd != NULL_LINK);
                    prev_waddr = next_rd;
                    prev_wdata = r_slot;
                end
                dlkl_pkg::CMD_DELETE: begin
                    next_we    = (prev_rd != NULL_LINK);
                    next_waddr = prev_rd;
                    next_wdata = next_rd;
                    prev_we    = (next_rd != NULL_LINK);
                    prev_waddr = next_rd;
                    prev_wdata = prev_rd;
                end
                default: begin
                    next_we = 1'b0;
                end
            endcase
        end
    end

    // head, tail and free map updates
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_free = r_free;
        if (i_ctl.clear) begin
            n_head = NULL_LINK;
            n_tail = NULL_LINK;
            n_free = '1;
        end else if (i_ctl.wr_new) begin
            n_free[r_slot[IW-1:0]] = 1'b0;
        end else if (i_ctl.wr_link) begin
            case (r_cmd)
                dlkl_pkg::CMD_INS_FRONT: begin
                    if (r_head == NULL_LINK) begin
                        n_tail = r_slot;
                    end
                    n_head = r_slot;
                end
                dlkl_pkg::CMD_INS_BACK: begin
                    if (r_tail == NULL_LINK) begin
                        n_head = r_slot;
                    end
                    n_tail = r_slot;
                end
                dlkl_pkg::CMD_INS_AFTER: begin
                    if (next_rd == NULL_LINK) begin
                        n_tail = r_slot;
                    end
                end
                dlkl_pkg::CMD_DELETE: begin
                    if (prev_rd == NULL_LINK) begin
                        n_head = next_rd;
                    end
                    if (next_rd == NULL_LINK) begin
                        n_tail = prev_rd;
                    end
                    n_free[r_cur[IW-1:0]] = 1'b1;
                end
                default: begin
                    n_head = r_head;
                end
            endcase
        end
    end

    // list control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= NULL_LINK;
            r_tail      <= NULL_LINK;
            r_free      <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_free <= n_free;
            if (i_ctl.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // slot field of a result, masked to the port width
    assign cur_ext  = {{dlkl_pkg::SLOT_W{1'b0}}, r_cur};
    assign slot_ext = {{dlkl_pkg::SLOT_W{1'b0}}, r_slot};

    always_comb begin
        case (i_ctl.slot_sel)
            dlkl_pkg::SLOT_ALLOC: slot_sel_val = slot_ext[dlkl_pkg::SLOT_W-1:0];
            dlkl_pkg::SLOT_CUR:   slot_sel_val = cur_ext[dlkl_pkg::SLOT_W-1:0];
            default:              slot_sel_val = '0;
        endcase
    end

    // command item, walk registers and result payload
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (i_ctl.load) begin
            r_cmd  <= i_cmd;
            r_key  <= i_key;
            r_skey <= (i_cmd == dlkl_pkg::CMD_INS_AFTER) ? i_anchor_key : i_key;
            r_slot <= free_idx;
            r_cnt  <= '0;
        end else if (i_ctl.step) begin
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_ctl.emit) begin
            r_status   <= i_ctl.status;
            r_key_out  <= i_ctl.key_sel ? key_rd : '0;
            r_slot_out <= slot_sel_val;
            r_last     <= i_ctl.last;
        end
    end

    // status towards the controller
    assign o_stat.cur_null  = (r_cur == NULL_LINK);
    assign o_stat.match     = (key_rd == r_skey);
    assign o_stat.next_null = (next_rd == NULL_LINK);
    assign o_stat.cnt_last  = (r_cnt == CNT_END);
    assign o_stat.full      = (r_free == '0);
    assign o_stat.empty     = (r_head == NULL_LINK);
    assign o_stat.out_room  = !r_out_valid || i_ready;

    assign o_valid   = r_out_valid;
    assign o_status  = r_status;
    assign o_key_out = r_key_out;
    assign o_slot    = r_slot_out;
    assign o_last    = r_last;

endmodule

// ===== rtl/core/dlkl_ctrl.sv =====
// command sequencer of the linked key list
`timescale 1ns / 1ps

module dlkl_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  dlkl_pkg::t_cmd     i_cmd,
    output logic               o_ready,
    input  dlkl_pkg::t_dp_stat i_stat,
    output dlkl_pkg::t_dp_cmd  o_ctl
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIND = 3'd1;
    localparam logic [2:0] S_NEW  = 3'd2;
    localparam logic [2:0] S_LINK = 3'd3;
    localparam logic [2:0] S_TRAV = 3'd4;
    localparam logic [2:0] S_RESP = 3'd5;
    localparam logic [2:0] S_CLR  = 3'd6;

    logic [2:0]        r_state, n_state;
    dlkl_pkg::t_cmd    r_cmd, n_cmd;
    dlkl_pkg::t_status r_status, n_status;
    logic              trav_last;

    assign trav_last = i_stat.next_null || i_stat.cnt_last;

    // next state and datapath commands
    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_status = r_status;
        o_ready  = 1'b0;
        o_ctl    = '0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctl.load = 1'b1;
                    n_cmd      = i_cmd;
                    case (i_cmd)
                        dlkl_pkg::CMD_INS_FRONT, dlkl_pkg::CMD_INS_BACK: begin
                            if (i_stat.full) begin
                                n_status = dlkl_pkg::ST_FULL;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_NEW;
                            end
                        end
                        dlkl_pkg::CMD_INS_AFTER: begin
                            if (i_stat.full) begin
                                n_status = dlkl_pkg::ST_FULL;
                                n_state  = S_RESP;
                            end else if (i_stat.empty) begin
                                n_status = dlkl_pkg::ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        dlkl_pkg::CMD_DELETE, dlkl_pkg::CMD_SEARCH: begin
                            if (i_stat.empty) begin
                                n_status = dlkl_pkg::ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        dlkl_pkg::CMD_CLEAR: begin
                            n_state = S_CLR;
                        end
                        dlkl_pkg::CMD_TRAVERSE: begin
                            if (i_stat.empty) begin
                                n_status = dlkl_pkg::ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_TRAV;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            // one node per cycle until the key matches or the list ends
            S_FIND: begin
                if (i_stat.cur_null) begin
                    n_status = dlkl_pkg::ST_NOT_FOUND;
                    n_state  = S_RESP;
                end else if (i_stat.match) begin
                    case (r_cmd)
                        dlkl_pkg::CMD_INS_AFTER: n_state = S_NEW;
                        dlkl_pkg::CMD_DELETE:    n_state = S_LINK;
                        default: begin
                            n_status = dlkl_pkg::ST_OK;
                            n_state  = S_RESP;
                        end
                    endcase
                end else begin
                    o_ctl.step = 1'b1;
                end
            end
            S_NEW: begin
                o_ctl.wr_new = 1'b1;
                n_state      = S_LINK;
            end
            S_LINK: begin
                o_ctl.wr_link = 1'b1;
                n_status      = dlkl_pkg::ST_OK;
                n_state       = S_RESP;
            end
            S_CLR: begin
                o_ctl.clear = 1'b1;
                n_status    = dlkl_pkg::ST_OK;
                n_state     = S_RESP;
            end
            // single result of every command but the unused one and a traversal of a non-empty list
            S_RESP: begin
                if (i_stat.out_room) begin
                    o_ctl.emit   = 1'b1;
                    o_ctl.status = r_status;
                    o_ctl.last   = 1'b1;
                    if (r_status == dlkl_pkg::ST_OK) begin
                        case (r_cmd)
                            dlkl_pkg::CMD_INS_FRONT, dlkl_pkg::CMD_INS_BACK,
                            dlkl_pkg::CMD_INS_AFTER: o_ctl.slot_sel = dlkl_pkg::SLOT_ALLOC;
                            dlkl_pkg::CMD_DELETE, dlkl_pkg::CMD_SEARCH:
                                o_ctl.slot_sel = dlkl_pkg::SLOT_CUR;
                            default: o_ctl.slot_sel = dlkl_pkg::SLOT_NONE;
                        endcase
                    end
                    n_state = S_IDLE;
                end
            end
            // one key per cycle while the receiver takes them
            S_TRAV: begin
                if (i_stat.out_room) begin
                    o_ctl.emit    = 1'b1;
                    o_ctl.status  = dlkl_pkg::ST_OK;
                    o_ctl.key_sel = 1'b1;
                    o_ctl.last    = trav_last;
                    o_ctl.step    = 1'b1;
                    if (trav_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // command and pending status of the current item
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_status <= n_status;
    end

endmodule

// ===== rtl/core/doubly_linked_key_list.sv =====
// Ordered list of signed 32-bit keys in a pool of POOL_DEPTH linked nodes.
// i_req carries one command item (cmd, key, anchor_key); o_rsp carries the
// result items (status, key_out, slot, last), last marking a command's final one.
// One command is worked on at a time: i_req.ready is high only while idle.
// Steps from acceptance to the result register, one node visited per cycle:
//   insert front/back: new node, link, result; clear: clear, result;
//   pool full or list empty: result; search: walk to the key, result;
//   insert after: walk to the anchor, new node, link, result; delete: walk, link,
//   result; key not found: walk the list, result; traversal: one key per cycle
//   while the receiver takes them, up to 16. The walk rate is set by the
// registered read of the node memories, whose address follows the link read.
// The block takes a new command the cycle after the last result is loaded.
// A stalled receiver holds the result register; the next result, and so
// each further traversal key, waits until the register is taken.
// Reset empties the list and marks every slot free; node memories are not cleared,
// as no entry is read before an insert has written it.
`timescale 1ns / 1ps

module doubly_linked_key_list #(
    parameter int POOL_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dlkl_req_if.sink          i_req,
    dlkl_rsp_if.source        o_rsp
);

    dlkl_pkg::t_dp_cmd  ctl;
    dlkl_pkg::t_dp_stat stat;
    logic               req_ready;

    // command sequencer
    dlkl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .i_cmd   (i_req.cmd),
        .o_ready (req_ready),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    // node pool and result register
    dlkl_datapath #(.POOL_DEPTH(POOL_DEPTH)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_req.cmd),
        .i_key        (i_req.key),
        .i_anchor_key (i_req.anchor_key),
        .i_ctl        (ctl),
        .o_stat       (stat),
        .o_valid      (o_rsp.valid),
        .i_ready      (o_rsp.ready),
        .o_status     (o_rsp.status),
        .o_key_out    (o_rsp.key_out),
        .o_slot       (o_rsp.slot),
        .o_last       (o_rsp.last)
    );

    assign i_req.ready = req_ready;

endmodule

// ===== rtl/core/dlkl_checker.sv =====
// port level checks of the linked key list, bound to the top level
`timescale 1ns / 1ps
`include "doubly_linked_key_list_macros.svh"

module dlkl_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input dlkl_pkg::t_cmd    i_req_cmd,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input dlkl_pkg::t_status i_rsp_status,
    input dlkl_pkg::t_key    i_rsp_key_out,
    input dlkl_pkg::t_slot   i_rsp_slot,
    input logic              i_rsp_last
);

    logic cmd_taken;
    logic rsp_failed;
    logic fail_clean;

    // real command taken, failure result shown, and its expected shape
    assign cmd_taken  = i_req_valid && i_req_ready && (i_req_cmd != dlkl_pkg::CMD_UNUSED);
    assign rsp_failed = i_rsp_valid && (i_rsp_status != dlkl_pkg::ST_OK);
    assign fail_clean = i_rsp_last && (i_rsp_slot == '0) && (i_rsp_key_out == '0);

    // a pending result is not withdrawn
    `DLKL_ASSERT(a_rsp_hold, i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)

    // reset leaves no result pending
    `DLKL_ASSERT_RST(a_rst_empty, !i_rst_n |=> !i_rsp_valid)

    // a real command blocks the next one
    `DLKL_ASSERT(a_one_at_a_time, cmd_taken |=> !i_req_ready)

    // failure results are single, with zero slot and key
    `DLKL_ASSERT(a_fail_single, rsp_failed |-> fail_clean)

endmodule

bind doubly_linked_key_list dlkl_checker u_dlkl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_req_cmd     (i_req.cmd),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_status  (o_rsp.status),
    .i_rsp_key_out (o_rsp.key_out),
    .i_rsp_slot    (o_rsp.slot),
    .i_rsp_last    (o_rsp.last)
);

// ===== bench/doubly_linked_key_list_tb.sv =====
// self-checking testbench of the linked key list: list commands, results and back-pressure
`timescale 1ns / 1ps

module doubly_linked_key_list_tb;

    localparam int POOL = 16;

    typedef logic [4:0] t_link;
    localparam t_link NIL = t_link'(POOL);

    localparam dlkl_pkg::t_key KEY_MIN = 32'sh8000_0000;
    localparam dlkl_pkg::t_key KEY_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        dlkl_pkg::t_status status;
        dlkl_pkg::t_key    key_out;
        dlkl_pkg::t_slot   slot;
        logic              last;
    } t_list_result;

    logic i_clk;
    logic i_rst_n;

    dlkl_req_if req_if();
    dlkl_rsp_if rsp_if();

    doubly_linked_key_list #(
        .POOL_DEPTH(POOL)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // shadow copy of the list
    dlkl_pkg::t_key  list_key  [POOL];
    t_link           list_next [POOL];
    t_link           list_prev [POOL];
    t_link           list_head;
    t_link           list_tail;
    logic [POOL-1:0] list_free;

    t_list_result   results_due[$];
    dlkl_pkg::t_key hot_keys[8];

    bit send_idle_en;
    bit recv_idle_en;
    int hold_req_cycles;

    int mismatch_count;
    int results_checked;
    int items_sent;
    int traverse_keys;
    int full_hits;
    int missing_hits;
    int empty_hits;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #6_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void owe(dlkl_pkg::t_status st, dlkl_pkg::t_key k, t_link s,
                                logic fin);
        t_list_result r;
        r.status  = st;
        r.key_out = k;
        r.slot    = s[dlkl_pkg::SLOT_W-1:0];
        r.last    = fin;
        results_due.push_back(r);
        if (st == dlkl_pkg::ST_FULL) full_hits++;
        if (st == dlkl_pkg::ST_NOT_FOUND) missing_hits++;
        if (st == dlkl_pkg::ST_EMPTY) empty_hits++;
    endfunction

    // first node from the head holding the key
    function automatic t_link locate(dlkl_pkg::t_key k);
        t_link cur;
        int    steps;
        cur = list_head;
        for (steps = 0; steps < POOL && cur != NIL; steps++) begin
            if (list_key[cur] == k) return cur;
            cur = list_next[cur];
        end
        return NIL;
    endfunction

    // lowest free slot, taken out of the free map
    function automatic t_link grab_slot();
        int i;
        for (i = 0; i < POOL; i++) begin
            if (list_free[i]) begin
                list_free[i] = 1'b0;
                return t_link'(i);
            end
        end
        return NIL;
    endfunction

    function automatic void list_reset();
        int i;
        for (i = 0; i < POOL; i++) begin
            list_key[i]  = '0;
            list_next[i] = '0;
            list_prev[i] = '0;
        end
        list_free = '1;
        list_head = NIL;
        list_tail = NIL;
    endfunction

    // apply one accepted command to the shadow list and queue its results
    function automatic void model_list_command(dlkl_pkg::t_cmd c, dlkl_pkg::t_key k,
                                               dlkl_pkg::t_key a);
        t_link s;
        t_link p;
        t_link n;
        t_link cur;
        int    emitted;
        case (c)
            dlkl_pkg::CMD_INS_FRONT, dlkl_pkg::CMD_INS_BACK: begin
                if (list_free == '0) begin
                    owe(dlkl_pkg::ST_FULL, '0, '0, 1'b1);
                    return;
                end
                s = grab_slot();
                list_key[s] = k;
                if (c == dlkl_pkg::CMD_INS_FRONT) begin
                    list_prev[s] = NIL;
                    list_next[s] = list_head;
                    if (list_head != NIL) list_prev[list_head] = s;
                    else list_tail = s;
                    list_head = s;
                end else begin
                    list_next[s] = NIL;
                    list_prev[s] = list_tail;
                    if (list_tail != NIL) list_next[list_tail] = s;
                    else list_head = s;
                    list_tail = s;
                end
                owe(dlkl_pkg::ST_OK, '0, s, 1'b1);
            end
            dlkl_pkg::CMD_INS_AFTER: begin
                // full takes precedence over the anchor search
                if (list_free == '0) begin
                    owe(dlkl_pkg::ST_FULL, '0, '0, 1'b1);
                    return;
                end
                if (list_head == NIL) begin
                    owe(dlkl_pkg::ST_EMPTY, '0, '0, 1'b1);
                    return;
                end
                p = locate(a);
                if (p == NIL) begin
                    owe(dlkl_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
                    return;
                end
                s = grab_slot();
                list_key[s] = k;
                n = list_next[p];
                list_next[s] = n;
                list_prev[s] = p;
                if (n != NIL) list_prev[n] = s;
                else list_tail = s;
                list_next[p] = s;
                owe(dlkl_pkg::ST_OK, '0, s, 1'b1);
            end
            dlkl_pkg::CMD_DELETE, dlkl_pkg::CMD_SEARCH: begin
                if (list_head == NIL) begin
                    owe(dlkl_pkg::ST_EMPTY, '0, '0, 1'b1);
                    return;
                end
                s = locate(k);
                if (s == NIL) begin
                    owe(dlkl_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
                    return;
                end
                if (c == dlkl_pkg::CMD_DELETE) begin
                    p = list_prev[s];
                    n = list_next[s];
                    if (p != NIL) list_next[p] = n;
                    else list_head = n;
                    if (n != NIL) list_prev[n] = p;
                    else list_tail = p;
                    list_free[s] = 1'b1;
                end
                owe(dlkl_pkg::ST_OK, '0, s, 1'b1);
            end
            dlkl_pkg::CMD_CLEAR: begin
                list_free = '1;
                list_head = NIL;
                list_tail = NIL;
                owe(dlkl_pkg::ST_OK, '0, '0, 1'b1);
            end
            dlkl_pkg::CMD_TRAVERSE: begin
                if (list_head == NIL) begin
                    owe(dlkl_pkg::ST_EMPTY, '0, '0, 1'b1);
                    return;
                end
                emitted = 0;
                cur = list_head;
                while (cur != NIL && emitted < dlkl_pkg::RES_MAX && emitted < POOL) begin
                    n = list_next[cur];
                    owe(dlkl_pkg::ST_OK, list_key[cur], '0,
                        (n == NIL || emitted + 1 == dlkl_pkg::RES_MAX));
                    traverse_keys++;
                    emitted++;
                    cur = n;
                end
            end
            default: begin
                // unused command: ignored by the block
            end
        endcase
    endfunction

    // key of a random node in the list, or any key when empty
    function automatic dlkl_pkg::t_key live_key();
        int start;
        int i;
        int s;
        start = $urandom_range(0, POOL - 1);
        for (i = 0; i < POOL; i++) begin
            s = (start + i) % POOL;
            if (!list_free[s]) return list_key[s];
        end
        return dlkl_pkg::t_key'($urandom);
    endfunction

    // keys biased towards ones held in the list so that matches are common
    function automatic dlkl_pkg::t_key pick_key();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45 && list_free != '1) return live_key();
        if (r < 75) return hot_keys[$urandom_range(0, 7)];
        return dlkl_pkg::t_key'($urandom);
    endfunction

    // offer one command item and update the shadow list once it is taken
    task automatic send_item(dlkl_pkg::t_cmd c, dlkl_pkg::t_key k, dlkl_pkg::t_key a);
        int gap;
        gap = send_idle_en ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.cmd        <= c;
        req_if.key        <= k;
        req_if.anchor_key <= a;
        do @(posedge i_clk); while (!req_if.ready);
        model_list_command(c, k, a);
        items_sent++;
    endtask

    // stop offering and wait until every queued result has come back
    task automatic settle();
        req_if.valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    // commands on an empty list, the unused command among them
    task automatic test_empty_list();
        send_item(dlkl_pkg::CMD_TRAVERSE, '0, '0);
        send_item(dlkl_pkg::CMD_SEARCH, 32'sd5, '0);
        send_item(dlkl_pkg::CMD_DELETE, KEY_MIN, '0);
        send_item(dlkl_pkg::CMD_INS_AFTER, 32'sd1, '0);
        send_item(dlkl_pkg::CMD_UNUSED, KEY_MAX, KEY_MIN);
    endtask

    // links at head, tail and middle, duplicates, missing keys, clear
    task automatic test_link_edits();
        send_item(dlkl_pkg::CMD_INS_FRONT, KEY_MIN, '0);
        send_item(dlkl_pkg::CMD_INS_BACK, KEY_MAX, '0);
        send_item(dlkl_pkg::CMD_INS_AFTER, 32'sd0, KEY_MIN);
        send_item(dlkl_pkg::CMD_INS_AFTER, -32'sd1, KEY_MAX);
        send_item(dlkl_pkg::CMD_INS_AFTER, 32'sd9, 32'sd12345);
        send_item(dlkl_pkg::CMD_INS_FRONT, 32'sd0, '0);
        send_item(dlkl_pkg::CMD_SEARCH, 32'sd0, '0);
        send_item(dlkl_pkg::CMD_DELETE, 32'sd0, '0);
        send_item(dlkl_pkg::CMD_SEARCH, 32'sd0, '0);
        send_item(dlkl_pkg::CMD_DELETE, -32'sd1, '0);
        send_item(dlkl_pkg::CMD_DELETE, KEY_MIN, '0);
        send_item(dlkl_pkg::CMD_SEARCH, 32'sd7, '0);
        send_item(dlkl_pkg::CMD_DELETE, 32'sd7, '0);
        send_item(dlkl_pkg::CMD_TRAVERSE, '0, '0);
        send_item(dlkl_pkg::CMD_CLEAR, '0, '0);
        send_item(dlkl_pkg::CMD_TRAVERSE, '0, '0);
        send_item(dlkl_pkg::CMD_INS_BACK, 32'sh5A5A_5A5A, '0);
        send_item(dlkl_pkg::CMD_CLEAR, '0, '0);
    endtask

    // fill the pool with random keys, then push against the full pool
    task automatic test_fill_to_full();
        dlkl_pkg::t_cmd c;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        while (list_free != '0) begin
            c = dlkl_pkg::t_cmd'($urandom_range(dlkl_pkg::CMD_INS_FRONT,
                                                dlkl_pkg::CMD_INS_AFTER));
            send_item(c, pick_key(), live_key());
        end
        send_item(dlkl_pkg::CMD_INS_FRONT, pick_key(), '0);
        send_item(dlkl_pkg::CMD_INS_BACK, pick_key(), '0);
        send_item(dlkl_pkg::CMD_INS_AFTER, pick_key(), dlkl_pkg::t_key'($urandom));
        send_item(dlkl_pkg::CMD_INS_AFTER, pick_key(), live_key());
        send_item(dlkl_pkg::CMD_TRAVERSE, '0, '0);
        send_item(dlkl_pkg::CMD_DELETE, live_key(), '0);
        send_item(dlkl_pkg::CMD_SEARCH, live_key(), '0);
        send_item(dlkl_pkg::CMD_INS_BACK, pick_key(), '0);
        send_item(dlkl_pkg::CMD_TRAVERSE, '0, '0);
        send_item(dlkl_pkg::CMD_CLEAR, '0, '0);
    endtask

    // long receiver hold-off while commands keep coming, then a full drain
    task automatic test_backpressure();
        int i;
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        hold_req_cycles = 90;
        for (i = 0; i < 5; i++) send_item(dlkl_pkg::CMD_INS_BACK, pick_key(), '0);
        send_item(dlkl_pkg::CMD_TRAVERSE, '0, '0);
        send_item(dlkl_pkg::CMD_SEARCH, live_key(), '0);
        send_item(dlkl_pkg::CMD_DELETE, live_key(), '0);
        send_item(dlkl_pkg::CMD_TRAVERSE, '0, '0);
        settle();
    endtask

    // chunks of random commands, each chunk leaning to growth, balance or shrinkage
    task automatic test_random_mix();
        int             counted;
        int             chunk;
        int             ins_pct;
        int             j;
        int             r;
        dlkl_pkg::t_cmd c;
        counted = 0;
        chunk   = 0;
        while (counted < 350) begin
            case ($urandom_range(0, 2))
                0:       ins_pct = 75;
                1:       ins_pct = 45;
                default: ins_pct = 15;
            endcase
            send_idle_en = ($urandom_range(0, 3) != 0);
            recv_idle_en = ($urandom_range(0, 3) != 0);
            for (j = 0; j < 20; j++) begin
                r = $urandom_range(0, 99);
                if (r < ins_pct) begin
                    c = dlkl_pkg::t_cmd'($urandom_range(dlkl_pkg::CMD_INS_FRONT,
                                                        dlkl_pkg::CMD_INS_AFTER));
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 45) c = dlkl_pkg::CMD_DELETE;
                    else if (r < 75) c = dlkl_pkg::CMD_SEARCH;
                    else if (r < 91) c = dlkl_pkg::CMD_TRAVERSE;
                    else if (r < 96) c = dlkl_pkg::CMD_CLEAR;
                    else c = dlkl_pkg::CMD_UNUSED;
                end
                send_item(c, pick_key(), pick_key());
                if (c != dlkl_pkg::CMD_UNUSED) counted++;
            end
            chunk++;
            // now and then the sender waits for every result
            if (chunk % 6 == 0) settle();
        end
    endtask

    // result side: random stalls, requested hold-offs and checking
    initial begin : result_sink
        int           stall_left;
        int           hold_left;
        t_list_result want;
        stall_left = 0;
        hold_left  = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready) begin
                results_checked++;
                if (results_due.size() == 0) begin
                    $error("result item with nothing awaited: status %0d key %0d",
                           rsp_if.status, rsp_if.key_out);
                    mismatch_count++;
                end else begin
                    want = results_due.pop_front();
                    if (rsp_if.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                        mismatch_count++;
                    end
                    if (rsp_if.key_out !== want.key_out) begin
                        $error("key_out: expected %0d, got %0d", want.key_out, rsp_if.key_out);
                        mismatch_count++;
                    end
                    if (rsp_if.slot !== want.slot) begin
                        $error("slot: expected %0d, got %0d", want.slot, rsp_if.slot);
                        mismatch_count++;
                    end
                    if (rsp_if.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, rsp_if.last);
                        mismatch_count++;
                    end
                end
                stall_left = recv_idle_en ? $urandom_range(0, 12) : 0;
            end
            if (hold_req_cycles > 0) begin
                hold_left       = hold_req_cycles;
                hold_req_cycles = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // stimulus sequence
    initial begin
        req_if.valid      <= 1'b0;
        req_if.cmd        <= dlkl_pkg::CMD_INS_FRONT;
        req_if.key        <= '0;
        req_if.anchor_key <= '0;
        i_rst_n           <= 1'b0;
        send_idle_en    = 1'b1;
        recv_idle_en    = 1'b1;
        hold_req_cycles = 0;
        hot_keys[0] = KEY_MIN;
        hot_keys[1] = KEY_MAX;
        hot_keys[2] = '0;
        hot_keys[3] = -32'sd1;
        hot_keys[4] = dlkl_pkg::t_key'($urandom);
        hot_keys[5] = dlkl_pkg::t_key'($urandom);
        hot_keys[6] = dlkl_pkg::t_key'($urandom);
        hot_keys[7] = dlkl_pkg::t_key'($urandom);
        list_reset();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_link_edits();
        test_fill_to_full();
        test_backpressure();
        test_random_mix();
        settle();

        $display("covered %0d command items with %0d results checked", items_sent,
                 results_checked);
        $display("traversal keys %0d, pool full %0d, key missing %0d, list empty %0d",
                 traverse_keys, full_hits, missing_hits, empty_hits);
        if (mismatch_count == 0 && results_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
